// ===== rtl/htrp_pkg.sv =====
// ----------------------------------------------------------------------------
// htrp_pkg
// shared types and codes of the trace record parser
// ----------------------------------------------------------------------------
package htrp_pkg;

	localparam int ADDR_BITS_DEF = 64;
	localparam int SIZE_BITS_DEF = 32;
	localparam int OUT_ADDR_W    = 64;
	localparam int OUT_SIZE_W    = 32;
	localparam int REC_NUM_W     = 32;
	localparam int CMD_DEPTH     = 4;

	localparam logic [1:0] RK_RECORD = 2'd0;
	localparam logic [1:0] RK_END    = 2'd1;
	localparam logic [1:0] RK_ERROR  = 2'd2;

	localparam logic [2:0] EC_NONE       = 3'd0;
	localparam logic [2:0] EC_SHORT_LINE = 3'd1;
	localparam logic [2:0] EC_BAD_TYPE   = 3'd2;
	localparam logic [2:0] EC_BAD_ADDR   = 3'd3;
	localparam logic [2:0] EC_NO_SIZE    = 3'd4;
	localparam logic [2:0] EC_BAD_SIZE   = 3'd5;

	localparam logic [2:0] AK_READ  = 3'd0;
	localparam logic [2:0] AK_WRITE = 3'd1;
	localparam logic [2:0] AK_FETCH = 3'd2;
	localparam logic [2:0] AK_MISC  = 3'd3;
	localparam logic [2:0] AK_COPY  = 3'd4;
	localparam logic [2:0] AK_INVAL = 3'd5;

	// one command from the front to the back
	typedef struct packed {
		logic       rec;
		logic       err;
		logic       fin;
		logic [2:0] access;
		logic [2:0] code;
	} cmd_ctl_t;

endpackage

// ===== rtl/htrp_front.sv =====
// ----------------------------------------------------------------------------
// htrp_front
// per-character line parser, turns items into record/error/end commands
// ----------------------------------------------------------------------------
module htrp_front
	import htrp_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_input,
	output logic                 cmd_push,
	output cmd_ctl_t             cmd_ctl,
	output logic [ADDR_BITS-1:0] cmd_addr,
	output logic [SIZE_BITS-1:0] cmd_size
);

	typedef enum logic [3:0] {
		PH_START,
		PH_AFTER_TYPE,
		PH_PRE_ADDR,
		PH_ADDR_FIRST,
		PH_ADDR,
		PH_PRE_SIZE,
		PH_SIZE_FIRST,
		PH_SIZE,
		PH_TAIL,
		PH_DISCARD
	} phase_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	phase_t               phase_q, phase_nxt, ph;
	logic [2:0]           held_q, held_nxt;
	logic [ADDR_BITS-1:0] addr_q, addr_nxt;
	logic [SIZE_BITS-1:0] size_q, size_nxt;
	logic                 blank, nl, is_x, skip;
	logic [4:0]           hex;
	logic [3:0]           tval;
	cmd_ctl_t             ctl;

	// {valid, digit}
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {valid, access kind}
	function automatic logic [3:0] type_dec(input logic [7:0] c);
		logic [3:0] r;
		r = 4'd0;
		unique case (c)
			8'h72, 8'h52: r = {1'b1, AK_READ};
			8'h77, 8'h57: r = {1'b1, AK_WRITE};
			8'h69, 8'h49: r = {1'b1, AK_FETCH};
			8'h6d, 8'h4d: r = {1'b1, AK_MISC};
			8'h63, 8'h43: r = {1'b1, AK_COPY};
			8'h76, 8'h56: r = {1'b1, AK_INVAL};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	assign blank = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
	assign nl    = (char_byte == CH_NL);
	assign is_x  = (char_byte == CH_X_LO) || (char_byte == CH_X_UP);
	assign hex   = hex_dec(char_byte);
	assign tval  = type_dec(char_byte);

	always_comb begin
		phase_nxt  = phase_q;
		held_nxt   = held_q;
		addr_nxt   = addr_q;
		size_nxt   = size_q;
		ctl        = '0;
		ctl.access = held_q;
		ctl.code   = EC_NONE;
		skip       = 1'b0;
		ph         = phase_q;

		// optional 0x prefix right after a leading zero
		if (phase_q == PH_ADDR_FIRST) begin
			ph = PH_ADDR;
			if (!end_of_input && is_x && addr_q == '0)
				skip = 1'b1;
		end else if (phase_q == PH_SIZE_FIRST) begin
			ph = PH_SIZE;
			if (!end_of_input && is_x && size_q == '0)
				skip = 1'b1;
		end

		if (skip) begin
			phase_nxt = ph;
		end else if (end_of_input) begin
			ctl.fin   = 1'b1;
			phase_nxt = PH_START;
			case (ph)
				PH_AFTER_TYPE: begin
					ctl.err  = 1'b1;
					ctl.code = EC_BAD_TYPE;
				end
				PH_PRE_ADDR: begin
					ctl.err  = 1'b1;
					ctl.code = EC_SHORT_LINE;
				end
				PH_ADDR, PH_PRE_SIZE: begin
					ctl.err  = 1'b1;
					ctl.code = EC_NO_SIZE;
				end
				PH_SIZE, PH_TAIL: begin
					ctl.rec = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			case (ph)
				PH_AFTER_TYPE: begin
					if (nl) begin
						ctl.err   = 1'b1;
						ctl.code  = EC_SHORT_LINE;
						phase_nxt = PH_START;
					end else if (blank) begin
						phase_nxt = PH_PRE_ADDR;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_TYPE;
						phase_nxt = PH_DISCARD;
					end
				end
				PH_PRE_ADDR: begin
					if (blank) begin
						phase_nxt = PH_PRE_ADDR;
					end else if (nl) begin
						ctl.err   = 1'b1;
						ctl.code  = EC_SHORT_LINE;
						phase_nxt = PH_START;
					end else if (hex[4]) begin
						addr_nxt  = ADDR_BITS'(hex[3:0]);
						phase_nxt = PH_ADDR_FIRST;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_ADDR;
						phase_nxt = PH_DISCARD;
					end
				end
				PH_ADDR: begin
					if (hex[4]) begin
						addr_nxt  = {addr_q[ADDR_BITS-5:0], hex[3:0]};
						phase_nxt = PH_ADDR;
					end else if (blank) begin
						phase_nxt = PH_PRE_SIZE;
					end else if (nl) begin
						ctl.err   = 1'b1;
						ctl.code  = EC_NO_SIZE;
						phase_nxt = PH_START;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_ADDR;
						phase_nxt = PH_DISCARD;
					end
				end
				PH_PRE_SIZE: begin
					if (blank) begin
						phase_nxt = PH_PRE_SIZE;
					end else if (nl) begin
						ctl.err   = 1'b1;
						ctl.code  = EC_NO_SIZE;
						phase_nxt = PH_START;
					end else if (hex[4]) begin
						size_nxt  = SIZE_BITS'(hex[3:0]);
						phase_nxt = PH_SIZE_FIRST;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_SIZE;
						phase_nxt = PH_DISCARD;
					end
				end
				PH_SIZE: begin
					if (hex[4]) begin
						size_nxt  = {size_q[SIZE_BITS-5:0], hex[3:0]};
						phase_nxt = PH_SIZE;
					end else if (blank) begin
						phase_nxt = PH_TAIL;
					end else if (nl) begin
						ctl.rec   = 1'b1;
						phase_nxt = PH_START;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_SIZE;
						phase_nxt = PH_DISCARD;
					end
				end
				PH_TAIL: begin
					if (nl) begin
						ctl.rec   = 1'b1;
						phase_nxt = PH_START;
					end
				end
				PH_DISCARD: begin
					if (nl)
						phase_nxt = PH_START;
				end
				default: begin
					phase_nxt = PH_START;
					if (blank) begin
						phase_nxt = PH_START;
					end else if (nl) begin
						ctl.err  = 1'b1;
						ctl.code = EC_SHORT_LINE;
					end else if (tval[3]) begin
						held_nxt  = tval[2:0];
						phase_nxt = PH_AFTER_TYPE;
					end else begin
						ctl.err   = 1'b1;
						ctl.code  = EC_BAD_TYPE;
						phase_nxt = PH_DISCARD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			held_q  <= '0;
			addr_q  <= '0;
			size_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
			addr_q  <= addr_nxt;
			size_q  <= size_nxt;
		end
	end

	assign cmd_push = accept && (ctl.rec || ctl.err || ctl.fin);
	assign cmd_ctl  = ctl;
	assign cmd_addr = addr_q;
	assign cmd_size = size_q;

endmodule

// ===== rtl/htrp_queue.sv =====
// ----------------------------------------------------------------------------
// htrp_queue
// small command queue between parser front and result back
// ----------------------------------------------------------------------------
module htrp_queue
	import htrp_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/htrp_back.sv =====
// ----------------------------------------------------------------------------
// htrp_back
// expands commands into result items, numbers records, holds the output stage
// ----------------------------------------------------------------------------
module htrp_back
	import htrp_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	output logic                  cmd_pop,
	input  cmd_ctl_t              cmd_ctl,
	input  logic [ADDR_BITS-1:0]  cmd_addr,
	input  logic [SIZE_BITS-1:0]  cmd_size,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            result_kind,
	output logic [2:0]            access_kind,
	output logic [OUT_ADDR_W-1:0] ref_address,
	output logic [OUT_SIZE_W-1:0] ref_size,
	output logic [2:0]            error_code,
	output logic [REC_NUM_W-1:0]  record_number,
	output logic                  last_of_run
);

	logic                  valid_q, pend_end_q;
	logic [REC_NUM_W-1:0]  count_q;
	logic [1:0]            kind_q;
	logic [2:0]            access_q, code_q;
	logic [OUT_ADDR_W-1:0] addr_q;
	logic [OUT_SIZE_W-1:0] size_q;
	logic [REC_NUM_W-1:0]  num_q;
	logic                  last_q;
	logic                  load_ok;

	assign load_ok = !valid_q || pop;
	assign cmd_pop = load_ok && !pend_end_q && !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pend_end_q <= 1'b0;
			count_q    <= '0;
		end else if (load_ok) begin
			if (pend_end_q) begin
				valid_q    <= 1'b1;
				pend_end_q <= 1'b0;
			end else if (!cmd_empty) begin
				valid_q    <= 1'b1;
				pend_end_q <= cmd_ctl.fin && (cmd_ctl.rec || cmd_ctl.err);
				if (cmd_ctl.rec)
					count_q <= count_q + 1'b1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_end_q || (!cmd_empty && !cmd_ctl.rec && !cmd_ctl.err)) begin
				kind_q   <= RK_END;
				access_q <= '0;
				addr_q   <= '0;
				size_q   <= '0;
				code_q   <= EC_NONE;
				num_q    <= count_q;
				last_q   <= 1'b1;
			end else if (cmd_ctl.rec) begin
				kind_q   <= RK_RECORD;
				access_q <= cmd_ctl.access;
				addr_q   <= OUT_ADDR_W'(cmd_addr);
				size_q   <= OUT_SIZE_W'(cmd_size);
				code_q   <= EC_NONE;
				num_q    <= count_q;
				last_q   <= !cmd_ctl.fin;
			end else begin
				kind_q   <= RK_ERROR;
				access_q <= '0;
				addr_q   <= '0;
				size_q   <= '0;
				code_q   <= cmd_ctl.code;
				num_q    <= count_q;
				last_q   <= !cmd_ctl.fin;
			end
		end
	end

	assign empty         = !valid_q;
	assign result_kind   = kind_q;
	assign access_kind   = access_q;
	assign ref_address   = addr_q;
	assign ref_size      = size_q;
	assign error_code    = code_q;
	assign record_number = num_q;
	assign last_of_run   = last_q;

endmodule

// ===== rtl/hex_trace_record_parser.sv =====
// ----------------------------------------------------------------------------
// hex_trace_record_parser
// text trace line parser: characters in, access records out
// ----------------------------------------------------------------------------
// input channel: push/full, one character or an end-of-input marker per item;
//   an item is taken at a clock edge with push high and full low
// result channel: empty/pop, the oldest result sits on the ports while empty
//   is low and leaves at an edge with pop high
// each item gives zero, one or two results (record or error, then end)
// a command is written into the command queue, then loaded into the output stage
// throughput: one item per cycle while full is low; the back end moves one
//   result per cycle while the output stage is free, so an item with two results
//   delays the next command, a gap absorbed by the four-entry command queue
// a stalled result (pop low) holds the output stage; the front keeps taking
//   items until the command queue fills, then full goes high
// reset clears the parse phase, accumulators, record count, command queue and output stage
// address and size accumulators wrap at ADDR_BITS and SIZE_BITS bits
// ----------------------------------------------------------------------------
module hex_trace_record_parser
	import htrp_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_input,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            result_kind,
	output logic [2:0]            access_kind,
	output logic [OUT_ADDR_W-1:0] ref_address,
	output logic [OUT_SIZE_W-1:0] ref_size,
	output logic [2:0]            error_code,
	output logic [REC_NUM_W-1:0]  record_number,
	output logic                  last_of_run
);

	localparam int CMD_W = $bits(cmd_ctl_t) + ADDR_BITS + SIZE_BITS;

	logic                 accept;
	logic                 f_push;
	cmd_ctl_t             f_ctl, b_ctl;
	logic [ADDR_BITS-1:0] f_addr, b_addr;
	logic [SIZE_BITS-1:0] f_size, b_size;
	logic                 q_empty, q_pop;
	logic [CMD_W-1:0]     q_rdata;

	assign accept = push && !full;

	htrp_front #(
		.ADDR_BITS (ADDR_BITS),
		.SIZE_BITS (SIZE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.cmd_push     (f_push),
		.cmd_ctl      (f_ctl),
		.cmd_addr     (f_addr),
		.cmd_size     (f_size)
	);

	htrp_queue #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_ctl, f_addr, f_size}),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_ctl, b_addr, b_size} = q_rdata;

	htrp_back #(
		.ADDR_BITS (ADDR_BITS),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (q_empty),
		.cmd_pop       (q_pop),
		.cmd_ctl       (b_ctl),
		.cmd_addr      (b_addr),
		.cmd_size      (b_size),
		.pop           (pop),
		.empty         (empty),
		.result_kind   (result_kind),
		.access_kind   (access_kind),
		.ref_address   (ref_address),
		.ref_size      (ref_size),
		.error_code    (error_code),
		.record_number (record_number),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== rtl/htrp_checker.sv =====
// ----------------------------------------------------------------------------
// htrp_checker
// port-level checks of the trace record parser
// ----------------------------------------------------------------------------
module htrp_checker
	import htrp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pop,
	input logic                  empty,
	input logic [1:0]            result_kind,
	input logic [OUT_ADDR_W-1:0] ref_address,
	input logic [2:0]            error_code,
	input logic                  last_of_run
);

	// end of trace always closes its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == RK_END) |-> last_of_run)
		else $error("end result not marked last");

	// records carry no error code
	a_rec_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == RK_RECORD) |-> (error_code == EC_NONE))
		else $error("record with error code");

	// errors carry a code and no address
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == RK_ERROR) |-> (error_code != EC_NONE && ref_address == '0))
		else $error("malformed error result");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(ref_address)))
		else $error("stalled result changed");

endmodule

bind hex_trace_record_parser htrp_checker u_htrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pop         (pop),
	.empty       (empty),
	.result_kind (result_kind),
	.ref_address (ref_address),
	.error_code  (error_code),
	.last_of_run (last_of_run)
);

// ===== bench/trace_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_parse_checker
// follows every accepted character through a line parser of its own and
// compares each popped result, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module trace_parse_checker
	import htrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_input,
	input  logic                  pop,
	input  logic                  empty,
	input  logic [1:0]            result_kind,
	input  logic [2:0]            access_kind,
	input  logic [OUT_ADDR_W-1:0] ref_address,
	input  logic [OUT_SIZE_W-1:0] ref_size,
	input  logic [2:0]            error_code,
	input  logic [REC_NUM_W-1:0]  record_number,
	input  logic                  last_of_run,
	output int                    fail_count,
	output int                    waiting,
	output int                    records_seen,
	output int                    errors_seen,
	output int                    ends_seen
);

	typedef enum logic [3:0] {
		LINE_START,
		AFTER_TYPE,
		PRE_ADDR,
		ADDR_FIRST,
		ADDR_DIGITS,
		PRE_SIZE,
		SIZE_FIRST,
		SIZE_DIGITS,
		LINE_TAIL,
		SKIP_LINE
	} line_phase_t;

	typedef struct {
		logic [1:0]            kind;
		logic [2:0]            access;
		logic [OUT_ADDR_W-1:0] address;
		logic [OUT_SIZE_W-1:0] size;
		logic [2:0]            code;
		logic [REC_NUM_W-1:0]  number;
		logic                  last;
	} trace_result_t;

	line_phase_t          phase     = LINE_START;
	logic [63:0]          addr_acc  = '0;
	logic [31:0]          size_acc  = '0;
	logic [2:0]           held_kind = '0;
	logic [31:0]          rec_count = '0;
	trace_result_t        predicted_results[$];
	trace_result_t        oldest;
	int                   fails = 0;
	int                   n_rec = 0;
	int                   n_err = 0;
	int                   n_end = 0;

	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic int access_value(input logic [7:0] c);
		case (c)
			"r", "R": return int'(AK_READ);
			"w", "W": return int'(AK_WRITE);
			"i", "I": return int'(AK_FETCH);
			"m", "M": return int'(AK_MISC);
			"c", "C": return int'(AK_COPY);
			"v", "V": return int'(AK_INVAL);
			default:  return -1;
		endcase
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [2:0] access,
			input logic [63:0] address, input logic [31:0] size, input logic [2:0] code);
		trace_result_t r;
		r.kind    = kind;
		r.access  = access;
		r.address = address;
		r.size    = size;
		r.code    = code;
		r.number  = rec_count;
		r.last    = 1'b0;
		predicted_results.push_back(r);
	endtask

	task automatic emit_record();
		emit(RK_RECORD, held_kind, addr_acc, size_acc, EC_NONE);
		rec_count = rec_count + 1'b1;
	endtask

	task automatic emit_error(input logic [2:0] code);
		emit(RK_ERROR, '0, '0, '0, code);
	endtask

	task automatic parse_char(input logic [7:0] c, input logic eoi);
		line_phase_t ph;
		int          digit;
		int          acc;
		int          first;
		logic        blank;
		logic        nl;
		ph    = phase;
		digit = hex_value(c);
		acc   = access_value(c);
		blank = (c == " " || c == "\t");
		nl    = (c == "\n");
		first = predicted_results.size();
		// a leading 0 may be followed by the x of a prefix
		if (ph == ADDR_FIRST) begin
			if (!eoi && (c == "x" || c == "X") && addr_acc == 0) begin
				phase = ADDR_DIGITS;
				return;
			end
			ph = ADDR_DIGITS;
		end else if (ph == SIZE_FIRST) begin
			if (!eoi && (c == "x" || c == "X") && size_acc == 0) begin
				phase = SIZE_DIGITS;
				return;
			end
			ph = SIZE_DIGITS;
		end
		if (eoi) begin
			case (ph)
				AFTER_TYPE:            emit_error(EC_BAD_TYPE);
				PRE_ADDR:              emit_error(EC_SHORT_LINE);
				ADDR_DIGITS, PRE_SIZE: emit_error(EC_NO_SIZE);
				SIZE_DIGITS, LINE_TAIL: emit_record();
				default: ;
			endcase
			emit(RK_END, '0, '0, '0, EC_NONE);
			phase = LINE_START;
		end else begin
			case (ph)
				AFTER_TYPE: begin
					if (nl) begin
						emit_error(EC_SHORT_LINE);
						phase = LINE_START;
					end else if (blank) begin
						phase = PRE_ADDR;
					end else begin
						emit_error(EC_BAD_TYPE);
						phase = SKIP_LINE;
					end
				end
				PRE_ADDR: begin
					if (nl) begin
						emit_error(EC_SHORT_LINE);
						phase = LINE_START;
					end else if (digit >= 0) begin
						addr_acc = 64'(digit);
						phase    = ADDR_FIRST;
					end else if (!blank) begin
						emit_error(EC_BAD_ADDR);
						phase = SKIP_LINE;
					end
				end
				ADDR_DIGITS: begin
					if (digit >= 0) begin
						addr_acc = (addr_acc << 4) + 64'(digit);
						phase    = ADDR_DIGITS;
					end else if (blank) begin
						phase = PRE_SIZE;
					end else if (nl) begin
						emit_error(EC_NO_SIZE);
						phase = LINE_START;
					end else begin
						emit_error(EC_BAD_ADDR);
						phase = SKIP_LINE;
					end
				end
				PRE_SIZE: begin
					if (nl) begin
						emit_error(EC_NO_SIZE);
						phase = LINE_START;
					end else if (digit >= 0) begin
						size_acc = 32'(digit);
						phase    = SIZE_FIRST;
					end else if (!blank) begin
						emit_error(EC_BAD_SIZE);
						phase = SKIP_LINE;
					end
				end
				SIZE_DIGITS: begin
					if (digit >= 0) begin
						size_acc = (size_acc << 4) + 32'(digit);
						phase    = SIZE_DIGITS;
					end else if (blank) begin
						phase = LINE_TAIL;
					end else if (nl) begin
						emit_record();
						phase = LINE_START;
					end else begin
						emit_error(EC_BAD_SIZE);
						phase = SKIP_LINE;
					end
				end
				LINE_TAIL: begin
					if (nl) begin
						emit_record();
						phase = LINE_START;
					end
				end
				SKIP_LINE: begin
					if (nl) phase = LINE_START;
				end
				default: begin
					phase = LINE_START;
					if (nl) begin
						emit_error(EC_SHORT_LINE);
					end else if (acc >= 0) begin
						held_kind = 3'(acc);
						phase     = AFTER_TYPE;
					end else if (!blank) begin
						emit_error(EC_BAD_TYPE);
						phase = SKIP_LINE;
					end
				end
			endcase
		end
		if (predicted_results.size() > first)
			predicted_results[predicted_results.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase     = LINE_START;
			addr_acc  = '0;
			size_acc  = '0;
			held_kind = '0;
			rec_count = '0;
			predicted_results.delete();
		end else begin
			if (push && !full)
				parse_char(char_byte, end_of_input);
			if (pop && !empty) begin
				if (predicted_results.size() == 0) begin
					$error("result of kind %0d popped with none expected", result_kind);
					fails++;
				end else begin
					oldest = predicted_results.pop_front();
					check_field("result_kind", 64'(oldest.kind), 64'(result_kind));
					check_field("access_kind", 64'(oldest.access), 64'(access_kind));
					check_field("ref_address", 64'(oldest.address), 64'(ref_address));
					check_field("ref_size", 64'(oldest.size), 64'(ref_size));
					check_field("error_code", 64'(oldest.code), 64'(error_code));
					check_field("record_number", 64'(oldest.number), 64'(record_number));
					check_field("last_of_run", 64'(oldest.last), 64'(last_of_run));
					case (oldest.kind)
						RK_RECORD: n_rec++;
						RK_ERROR:  n_err++;
						default:   n_end++;
					endcase
				end
			end
		end
		fail_count   <= fails;
		waiting      <= predicted_results.size();
		records_seen <= n_rec;
		errors_seen  <= n_err;
		ends_seen    <= n_end;
	end

endmodule

// ===== bench/tb_hex_trace_record_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_trace_record_parser
// feeds trace text to the parser one character at a time: a few directed
// lines, then random lines, mostly well formed, some cut short, corrupted
// or pure noise, under three stall patterns; the checker scores the results
// ----------------------------------------------------------------------------
module tb_hex_trace_record_parser;
	import htrp_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 170;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} trace_char_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  push         = 1'b0;
	logic [7:0]            char_byte    = '0;
	logic                  end_of_input = 1'b0;
	logic                  pop          = 1'b0;
	logic                  full;
	logic                  empty;
	logic [1:0]            result_kind;
	logic [2:0]            access_kind;
	logic [OUT_ADDR_W-1:0] ref_address;
	logic [OUT_SIZE_W-1:0] ref_size;
	logic [2:0]            error_code;
	logic [REC_NUM_W-1:0]  record_number;
	logic                  last_of_run;

	int fail_count;
	int waiting;
	int records_seen;
	int errors_seen;
	int ends_seen;
	int send_idle   = 33;
	int recv_idle   = 69;
	int chars_sent  = 0;
	int cycle_count = 0;
	trace_char_t text_q[$];

	hex_trace_record_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_byte     (char_byte),
		.end_of_input  (end_of_input),
		.pop           (pop),
		.empty         (empty),
		.result_kind   (result_kind),
		.access_kind   (access_kind),
		.ref_address   (ref_address),
		.ref_size      (ref_size),
		.error_code    (error_code),
		.record_number (record_number),
		.last_of_run   (last_of_run)
	);

	trace_parse_checker parse_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_byte     (char_byte),
		.end_of_input  (end_of_input),
		.pop           (pop),
		.empty         (empty),
		.result_kind   (result_kind),
		.access_kind   (access_kind),
		.ref_address   (ref_address),
		.ref_size      (ref_size),
		.error_code    (error_code),
		.record_number (record_number),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.waiting       (waiting),
		.records_seen  (records_seen),
		.errors_seen   (errors_seen),
		.ends_seen     (ends_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("tb_hex_trace_record_parser: FAIL");
		$finish;
	end

	task automatic add_char(input logic [7:0] c);
		trace_char_t t;
		t.ch  = c;
		t.eoi = 1'b0;
		text_q.push_back(t);
	endtask

	task automatic add_end();
		trace_char_t t;
		t.ch  = 8'($urandom_range(255));
		t.eoi = 1'b1;
		text_q.push_back(t);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic add_blanks(input int n);
		repeat (n) add_char($urandom_range(1) ? 8'h20 : 8'h09);
	endtask

	// hex number, sometimes with a prefix, sometimes long enough to wrap
	task automatic add_number(input int short_max, input int long_min, input int long_max);
		string hexchars;
		int    n;
		hexchars = "0123456789abcdefABCDEF";
		if ($urandom_range(2) == 0) begin
			add_char(($urandom_range(5) == 0) ? hexchars[$urandom_range(21)] : 8'h30);
			add_char($urandom_range(1) ? 8'h78 : 8'h58);
			n = $urandom_range(short_max);
		end else begin
			n = $urandom_range(short_max, 1);
		end
		if ($urandom_range(7) == 0)
			n = $urandom_range(long_max, long_min);
		repeat (n) add_char(hexchars[$urandom_range(21)]);
	endtask

	task automatic build_line();
		string letters;
		letters = "rwimcvRWIMCV";
		add_blanks($urandom_range(2));
		add_char(letters[$urandom_range(11)]);
		add_blanks(($urandom_range(3) == 0) ? 2 : 1);
		add_number(8, 17, 20);
		add_blanks($urandom_range(3, 1));
		add_number(4, 9, 11);
		if ($urandom_range(2) == 0) begin
			add_blanks(1);
			repeat ($urandom_range(5, 1)) add_char(8'($urandom_range(8'h7e, 8'h21)));
		end
	endtask

	task automatic send_item(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		char_byte    <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (full);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_item(text_q[i].ch, text_q[i].eoi);
		text_q.delete();
	endtask

	task automatic random_line();
		int sel;
		int keep;
		int pos;
		sel = $urandom_range(99);
		build_line();
		if (sel < 70) begin
			if ($urandom_range(9) == 0) add_end();
			else add_char("\n");
		end else if (sel < 85) begin
			// cut short at any phase
			keep = $urandom_range(text_q.size() - 1);
			while (text_q.size() > keep) void'(text_q.pop_back());
			if ($urandom_range(1)) add_end();
			else add_char("\n");
		end else if (sel < 95) begin
			pos = $urandom_range(text_q.size() - 1);
			text_q[pos].ch = 8'($urandom_range(255));
			if ($urandom_range(3) == 0) add_end();
			else add_char("\n");
		end else begin
			text_q.delete();
			repeat ($urandom_range(6, 1)) add_char(8'($urandom_range(255)));
			add_char("\n");
		end
		send_text();
	endtask

	initial begin
		int phase_target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// end at line start, upper case type and prefixes, odd bytes,
		// end after a type letter, end right after the size
		add_end();
		add_str("R 0xF 0X1\n");
		add_char(8'hff);
		add_char("\n");
		add_char(8'h00);
		add_char("\n");
		add_str("c");
		add_end();
		add_str("i 0 0");
		add_end();
		send_text();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin send_idle = 33; recv_idle = 69; end
				1: begin send_idle = 69; recv_idle = 33; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			phase_target = chars_sent + ITEMS_PER_PHASE;
			while (chars_sent < phase_target) random_line();
		end
		push <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d characters under three stall patterns", chars_sent);
		$display("results: %0d records, %0d format errors, %0d end markers",
			records_seen, errors_seen, ends_seen);
		if (fail_count == 0)
			$display("tb_hex_trace_record_parser: PASS");
		else
			$display("tb_hex_trace_record_parser: FAIL");
		$finish;
	end

endmodule
